// File: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the time-ordered event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int DefQueueDepth  = 64;
  localparam int DefTimeBits    = 31;
  localparam int DefPayloadBits = 32;

  localparam int FuncW   = 2;
  localparam int StatusW = 2;
  localparam int OccW    = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_ORD_INSERT  = 2'd0,
    FUNC_HEAD_INSERT = 2'd1,
    FUNC_POP         = 2'd2,
    FUNC_NOP         = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // controls fanned out to every cell
  typedef struct packed {
    logic cmp_en;    // compare phase: cells latch their placement flag
    logic ins_en;    // apply phase: insert the new word
    logic pop_en;    // apply phase: shift towards the head
    logic head_ins;  // unconditional insert at the front
  } teq_ctl_t;

endpackage

// File: rtl/teq_if.sv
// ----------------------------------------------------------------------------
// teq_in_if
// Valid/ready channel carrying one queue operation word.
// ----------------------------------------------------------------------------
interface teq_in_if
  import teq_pkg::*;
#(
  parameter int TimeBits    = DefTimeBits,
  parameter int PayloadBits = DefPayloadBits
);
  logic                   valid;
  logic                   ready;
  logic [FuncW-1:0]       func;
  logic [TimeBits-1:0]    event_time;
  logic [PayloadBits-1:0] event_payload;

  modport source (output valid, func, event_time, event_payload, input ready);
  modport sink   (input valid, func, event_time, event_payload, output ready);
endinterface

// ----------------------------------------------------------------------------
// teq_out_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface teq_out_if
  import teq_pkg::*;
#(
  parameter int TimeBits    = DefTimeBits,
  parameter int PayloadBits = DefPayloadBits
);
  logic                   valid;
  logic                   ready;
  logic [StatusW-1:0]     status;
  logic [TimeBits-1:0]    out_time;
  logic [PayloadBits-1:0] out_payload;
  logic [OccW-1:0]        occupancy;

  modport source (output valid, status, out_time, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_time, out_payload, occupancy, output ready);
endinterface

// File: rtl/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the event list: holds an entry, decides whether the new
// event lands here and shifts data to or from its neighbours.
// ----------------------------------------------------------------------------
module teq_cell
  import teq_pkg::*;
#(
  parameter int Idx         = 0,
  parameter int TimeBits    = DefTimeBits,
  parameter int PayloadBits = DefPayloadBits,
  parameter int CntW        = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  teq_ctl_t               ctl_i,
  input  logic [CntW-1:0]        count_i,
  input  logic [TimeBits-1:0]    new_time_i,
  input  logic [PayloadBits-1:0] new_payload_i,
  input  logic [TimeBits-1:0]    left_time_i,
  input  logic [PayloadBits-1:0] left_payload_i,
  input  logic [TimeBits-1:0]    right_time_i,
  input  logic [PayloadBits-1:0] right_payload_i,
  input  logic                   hit_left_i,
  output logic                   hit_o,
  output logic [TimeBits-1:0]    time_o,
  output logic [PayloadBits-1:0] payload_o
);

  logic [TimeBits-1:0]    time_q, time_d;
  logic [PayloadBits-1:0] payload_q, payload_d;
  logic                   sel_q, sel_d;
  logic                   flag;

  // head slot compares strictly below, the rest stop at the first >= entry
  always_comb begin
    if (Idx == 0) begin
      flag = ctl_i.head_ins || (new_time_i < time_q);
    end else begin
      flag = (time_q >= new_time_i);
    end
  end

  always_comb begin
    sel_d = sel_q;
    if (ctl_i.cmp_en) begin
      sel_d = (count_i == CntW'(Idx)) || ((CntW'(Idx) < count_i) && flag);
    end
  end

  // insertion point lies at or left of this slot
  assign hit_o = hit_left_i | sel_q;

  always_comb begin
    time_d    = time_q;
    payload_d = payload_q;
    if (ctl_i.ins_en) begin
      if (hit_left_i) begin
        time_d    = left_time_i;
        payload_d = left_payload_i;
      end else if (sel_q) begin
        time_d    = new_time_i;
        payload_d = new_payload_i;
      end
    end else if (ctl_i.pop_en) begin
      time_d    = right_time_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q    <= time_d;
    payload_q <= payload_d;
  end

  assign time_o    = time_q;
  assign payload_o = payload_q;

endmodule

// File: rtl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Future-event list kept in a row of slot cells, head in cell 0.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_i     in   valid/ready    func, event_time, event_payload
//  out_o    out  valid/ready    status, out_time, out_payload, occupancy
//
//  Each operation passes through accept (idle), compare in every cell, then
//  shift/insert and load of the result register. A new word is accepted
//  only in idle with the result register free or being taken, so no word is
//  taken while one is in flight. The insert point is found by an OR chain
//  across the cells. Reset empties the queue; slot contents are not cleared.
//  A stalled result holds the block in idle until it is taken.
// ----------------------------------------------------------------------------
module time_ordered_event_queue
  import teq_pkg::*;
#(
  parameter int QueueDepth  = DefQueueDepth,
  parameter int TimeBits    = DefTimeBits,
  parameter int PayloadBits = DefPayloadBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  teq_in_if.sink    in_i,
  teq_out_if.source out_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [FuncW-1:0]       func_q;
  logic [TimeBits-1:0]    time_q;
  logic [PayloadBits-1:0] payload_q;
  logic [CntW-1:0]        count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic [StatusW-1:0]     status_q, status_d;
  logic [TimeBits-1:0]    out_time_q, out_time_d;
  logic [PayloadBits-1:0] out_payload_q, out_payload_d;

  teq_ctl_t               ctl;
  logic                   in_fire;
  logic                   is_insert, is_pop, full, empty;

  logic [TimeBits-1:0]    cell_time [QueueDepth];
  logic [PayloadBits-1:0] cell_payload [QueueDepth];
  logic                   cell_hit [QueueDepth];

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  assign is_insert = func_q inside {FUNC_ORD_INSERT, FUNC_HEAD_INSERT};
  assign is_pop    = (func_q == FUNC_POP);
  assign full      = (count_q == CntW'(QueueDepth));
  assign empty     = (count_q == '0);

  always_comb begin
    ctl.cmp_en   = (state_q == ST_CMP);
    ctl.ins_en   = (state_q == ST_APPLY) && is_insert && !full;
    ctl.pop_en   = (state_q == ST_APPLY) && is_pop && !empty;
    ctl.head_ins = (func_q == FUNC_HEAD_INSERT);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d       = count_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    out_time_d    = out_time_q;
    out_payload_d = out_payload_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_APPLY) begin
      out_valid_d   = 1'b1;
      status_d      = STATUS_OK;
      out_time_d    = '0;
      out_payload_d = '0;
      case (func_q)
        FUNC_ORD_INSERT, FUNC_HEAD_INSERT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        FUNC_POP: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            out_time_d    = cell_time[0];
            out_payload_d = cell_payload[0];
            count_d       = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      func_q      <= FUNC_NOP;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        func_q <= in_i.func;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      time_q    <= in_i.event_time;
      payload_q <= in_i.event_payload;
    end
    status_q      <= status_d;
    out_time_q    <= out_time_d;
    out_payload_q <= out_payload_d;
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [TimeBits-1:0]    left_time, right_time;
    logic [PayloadBits-1:0] left_payload, right_payload;
    logic                   hit_left;

    if (i == 0) begin : g_head
      assign left_time    = time_q;
      assign left_payload = payload_q;
      assign hit_left     = 1'b0;
    end else begin : g_body
      assign left_time    = cell_time[i-1];
      assign left_payload = cell_payload[i-1];
      assign hit_left     = cell_hit[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_time    = time_q;
      assign right_payload = payload_q;
    end else begin : g_inner
      assign right_time    = cell_time[i+1];
      assign right_payload = cell_payload[i+1];
    end

    teq_cell #(
      .Idx        (i),
      .TimeBits   (TimeBits),
      .PayloadBits(PayloadBits),
      .CntW       (CntW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .count_i        (count_q),
      .new_time_i     (time_q),
      .new_payload_i  (payload_q),
      .left_time_i    (left_time),
      .left_payload_i (left_payload),
      .right_time_i   (right_time),
      .right_payload_i(right_payload),
      .hit_left_i     (hit_left),
      .hit_o          (cell_hit[i]),
      .time_o         (cell_time[i]),
      .payload_o      (cell_payload[i])
    );
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.out_time    = out_time_q;
  assign out_o.out_payload = out_payload_q;
  assign out_o.occupancy   = OccW'(count_q);

endmodule
